// ----- design/low_rank_projection_iteration_top_assert.svh -----
// Assertion macros for the low-rank projection iteration block.
`ifndef LOW_RANK_PROJECTION_ITERATION_TOP_ASSERT_SVH
`define LOW_RANK_PROJECTION_ITERATION_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The condition c must hold in the same cycle as a.
`define LRPI_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lrpi: same-cycle check failed");

// The condition c must hold in the cycle after a.
`define LRPI_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lrpi: next-cycle check failed");

`else

`define LRPI_ASSERT_IMPL(label, clk, rst_n, a, c)
`define LRPI_ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

// ----- design/lrpi_pkg.sv -----
// Types, constants and fixed-point helpers for the low-rank projection iteration block.
package lrpi_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int BAS_AW   = ROW_W + COL_W;
  localparam int DATA_W   = 32;
  localparam int ACC_W    = 64;
  localparam int STEP_W   = 8;
  localparam int CFG_ROWS_W = 7;
  localparam int CFG_COLS_W = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;

  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(MAX_ROWS);
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(MAX_COLS);
  localparam logic [DATA_W-1:0]     GAIN_RESET = DATA_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    ACT_LOAD_BASIS = 2'd0,
    ACT_LOAD_VEC   = 2'd1,
    ACT_ITERATE    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROJ,
    S_PROJ_WAIT,
    S_BACK,
    S_BACK_WAIT,
    S_GAIN,
    S_OUT
  } state_e;

  typedef struct packed {
    action_e                   action;
    logic [ROW_W-1:0]          row_index;
    logic [COL_W-1:0]          col_index;
    logic signed [DATA_W-1:0]  load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_value;
    logic [ROW_W-1:0]          out_row;
    logic [STEP_W-1:0]         step_number;
    logic                      last_of_run;
  } out_item_t;

  // Floor shift by the fraction width, then saturate to a signed data word.
  function automatic logic [DATA_W-1:0] scale_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W-FRAC_BITS-1:0] sh;
    logic [ACC_W-FRAC_BITS-DATA_W:0] top;
    sh  = acc[ACC_W-1:FRAC_BITS];
    top = sh[ACC_W-FRAC_BITS-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return sh[DATA_W-1:0];
    end else if (sh[ACC_W-FRAC_BITS-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- design/low_rank_projection_iteration_top.sv -----
// Top level of the low-rank projection iteration block: memories, MAC pipeline and sequencer.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      in_valid_i / in_ready_o      in_item_t  (action, indexes, value)
//   out      output     out_valid_o / out_ready_i    out_item_t (value, row, step, last)
//   cfg      input      cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// Load requests are written as they are accepted. An iterate request is paced by
// the single shared 32x32 multiplier, which performs one multiply-accumulate per
// cycle while a sweep runs, plus the drain of its three-stage pipeline (read,
// multiply, accumulate) after each sum.
// The output register lets a new request enter while the last result waits;
// a stalled output holds the sequencer in its emit step. Reset clears control
// state and configuration only; the memories hold nothing defined until loaded.
module low_rank_projection_iteration_top
  import lrpi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [CFG_ROWS_W-1:0] rows_q;
  logic [CFG_COLS_W-1:0] cols_q;
  logic [DATA_W-1:0]     gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i[CFG_ROWS_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[CFG_COLS_W-1:0];
        CFG_GAIN: gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes are the registers clamped to 1..MAX; we keep the last index.
  logic [CFG_ROWS_W-1:0] n_eff;
  logic [CFG_COLS_W-1:0] k_eff;
  logic [ROW_W-1:0]      n_last;
  logic [COL_W-1:0]      k_last;

  always_comb begin
    if (rows_q == '0) begin
      n_eff = CFG_ROWS_W'(1);
    end else if (rows_q > CFG_ROWS_W'(MAX_ROWS)) begin
      n_eff = CFG_ROWS_W'(MAX_ROWS);
    end else begin
      n_eff = rows_q;
    end
    if (cols_q == '0) begin
      k_eff = CFG_COLS_W'(1);
    end else if (cols_q > CFG_COLS_W'(MAX_COLS)) begin
      k_eff = CFG_COLS_W'(MAX_COLS);
    end else begin
      k_eff = cols_q;
    end
    n_last = ROW_W'(n_eff - CFG_ROWS_W'(1));
    k_last = COL_W'(k_eff - CFG_COLS_W'(1));
  end

  // Sequencer registers.
  state_e            state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Pipeline control: read stage, multiply stage, then a done flag after the
  // final accumulate.
  logic rv_q, rfirst_q, rlast_q, rback_q;
  logic pv_q, pfirst_q, plast_q;
  logic done_q;
  logic issue, issue_first, issue_last, issue_back;

  // Memory ports.
  logic                   bas_we;
  logic [BAS_AW-1:0]      bas_wa;
  logic [BAS_AW-1:0]      bas_ra;
  logic [DATA_W-1:0]      bas_rd_q;
  logic                   vec_we;
  logic [ROW_W-1:0]       vec_wa;
  logic [DATA_W-1:0]      vec_wd;
  logic [DATA_W-1:0]      vec_rd_q;
  logic                   proj_we;
  logic [DATA_W-1:0]      proj_rd_q;

  // Datapath registers.
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod_d, prod_q;
  logic                     prod_en;
  logic [ACC_W-1:0]         acc_q;
  logic [DATA_W-1:0]        y_q;
  logic                     y_en;

  // Output register.
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      out_load;
  logic      in_accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Basis memory: written by load requests, read at {row, column}.
  logic [DATA_W-1:0] bas_mem [MAX_ROWS*MAX_COLS];

  assign bas_we = in_accept && (in_data_i.action == ACT_LOAD_BASIS);
  assign bas_wa = {in_data_i.row_index, in_data_i.col_index};
  assign bas_ra = {row_q, col_q};

  always_ff @(posedge clk_i) begin
    if (bas_we) begin
      bas_mem[bas_wa] <= in_data_i.load_value;
    end
    bas_rd_q <= bas_mem[bas_ra];
  end

  // Vector memory: written by load requests and by the emit step.
  logic [DATA_W-1:0] vec_mem [MAX_ROWS];

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= vec_wd;
    end
    vec_rd_q <= vec_mem[row_q];
  end

  // Projection memory: one entry per basis column.
  logic [DATA_W-1:0] proj_mem [MAX_COLS];

  always_ff @(posedge clk_i) begin
    if (proj_we) begin
      proj_mem[col_q] <= scale_sat(acc_q);
    end
    proj_rd_q <= proj_mem[col_q];
  end

  // Sequencer: next state, counters and memory write controls.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    step_d      = step_q;
    issue       = 1'b0;
    issue_first = 1'b0;
    issue_last  = 1'b0;
    issue_back  = 1'b0;
    proj_we     = 1'b0;
    y_en        = 1'b0;
    out_load    = 1'b0;
    vec_we      = 1'b0;
    vec_wa      = in_data_i.row_index;
    vec_wd      = in_data_i.load_value;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_data_i.action)
            ACT_LOAD_VEC: vec_we = 1'b1;
            ACT_ITERATE: begin
              row_d   = '0;
              col_d   = '0;
              state_d = S_PROJ;
            end
            default: ;
          endcase
        end
      end
      // Sweep the rows of column col_q against the current vector.
      S_PROJ: begin
        issue       = 1'b1;
        issue_first = (row_q == '0);
        issue_last  = (row_q == n_last);
        if (row_q == n_last) begin
          state_d = S_PROJ_WAIT;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      S_PROJ_WAIT: begin
        if (done_q) begin
          proj_we = 1'b1;
          row_d   = '0;
          if (col_q == k_last) begin
            col_d   = '0;
            state_d = S_BACK;
          end else begin
            col_d   = col_q + COL_W'(1);
            state_d = S_PROJ;
          end
        end
      end
      // Sweep the columns of row row_q against the projection.
      S_BACK: begin
        issue       = 1'b1;
        issue_back  = 1'b1;
        issue_first = (col_q == '0);
        issue_last  = (col_q == k_last);
        if (col_q == k_last) begin
          state_d = S_BACK_WAIT;
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      S_BACK_WAIT: begin
        if (done_q) begin
          y_en    = 1'b1;
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        state_d = S_OUT;
      end
      // Emit the new element once the output register is free.
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          vec_we   = 1'b1;
          vec_wa   = row_q;
          vec_wd   = scale_sat(prod_q);
          col_d    = '0;
          if (row_q == n_last) begin
            step_d  = step_q + STEP_W'(1);
            state_d = S_IDLE;
          end else begin
            row_d   = row_q + ROW_W'(1);
            state_d = S_BACK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      step_q  <= step_d;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q     <= 1'b0;
      rfirst_q <= 1'b0;
      rlast_q  <= 1'b0;
      rback_q  <= 1'b0;
      pv_q     <= 1'b0;
      pfirst_q <= 1'b0;
      plast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rv_q     <= issue;
      rfirst_q <= issue_first;
      rlast_q  <= issue_last;
      rback_q  <= issue_back;
      pv_q     <= rv_q;
      pfirst_q <= rfirst_q;
      plast_q  <= rlast_q;
      done_q   <= pv_q && plast_q;
    end
  end

  // The one multiplier serves the two sweeps and the gain step.
  always_comb begin
    if (state_q == S_GAIN) begin
      mul_a = gain_q;
      mul_b = y_q;
    end else begin
      mul_a = bas_rd_q;
      mul_b = rback_q ? proj_rd_q : vec_rd_q;
    end
    prod_d  = mul_a * mul_b;
    prod_en = rv_q || (state_q == S_GAIN);
  end

  always_ff @(posedge clk_i) begin
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (pv_q) begin
      acc_q <= (pfirst_q ? '0 : acc_q) + prod_q;
    end
    if (y_en) begin
      y_q <= scale_sat(acc_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.out_value   <= scale_sat(prod_q);
      out_data_q.out_row     <= row_q;
      out_data_q.step_number <= step_q + STEP_W'(1);
      out_data_q.last_of_run <= (row_q == n_last);
    end
  end

  // Assertions.
  `include "low_rank_projection_iteration_top_assert.svh"

  `LRPI_ASSERT_IMPL(a_done_in_wait, clk_i, rst_ni, done_q, (state_q == S_PROJ_WAIT) || (state_q == S_BACK_WAIT))
  `LRPI_ASSERT_IMPL(a_acc_in_sweep, clk_i, rst_ni, pv_q, (state_q == S_PROJ) || (state_q == S_PROJ_WAIT) || (state_q == S_BACK) || (state_q == S_BACK_WAIT))
  `LRPI_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, out_load && (row_q == n_last), (state_q == S_IDLE) && out_valid_o && out_data_o.last_of_run)

endmodule

// ----- tb/sv/low_rank_projection_iteration_top_tb.sv -----
// Self-checking testbench for the low-rank projection iteration block.
module low_rank_projection_iteration_top_tb;
  import lrpi_pkg::*;

  // Action code 3 is not defined by the block; it must be swallowed silently.
  localparam action_e ACT_UNUSED = action_e'(2'd3);

  // The limit is several times the length of a run in which every request here
  // were a full-height iterate request with its 64 elements drained under the
  // heaviest stalls.
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  // Loads land as they are accepted and the multiply-accumulate pipeline is three
  // deep, so this many quiet cycles after the last element leave the block idle.
  localparam int SETTLE_CYCLES = 32;

  // Shadow copy of the block: basis, vector, projection, step count and
  // configuration. Every accepted request advances it, and every iterate
  // request queues the elements the block has to return.
  class projection_shadow;
    logic signed [DATA_W-1:0] basis [MAX_ROWS][MAX_COLS];
    logic signed [DATA_W-1:0] vec [MAX_ROWS];
    logic signed [DATA_W-1:0] proj [MAX_COLS];
    logic [STEP_W-1:0] step_count;
    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [CFG_COLS_W-1:0] cols_reg;
    logic signed [DATA_W-1:0] gain_reg;
    out_item_t awaited_elements [$];
    int mismatch_count;

    function new();
      step_count = '0;
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      gain_reg = GAIN_RESET;
      mismatch_count = 0;
    endfunction

    function int active_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function int active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_ROWS: rows_reg = data[CFG_ROWS_W-1:0];
        CFG_COLS: cols_reg = data[CFG_COLS_W-1:0];
        CFG_GAIN: gain_reg = data;
        default: ;
      endcase
    endfunction

    // Arithmetic shift down by the fraction width, then clip to a signed word.
    function logic signed [DATA_W-1:0] floor_clip(longint acc);
      longint sh;
      sh = acc >>> FRAC_BITS;
      if (sh > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (sh < -64'sd2147483648) return 32'h8000_0000;
      return sh[DATA_W-1:0];
    endfunction

    // p = U^T x, then x = gain * (U p); the 64-bit sums wrap freely.
    function void predict_iteration();
      int n;
      int k;
      longint acc;
      logic signed [DATA_W-1:0] y;
      out_item_t elem;
      n = active_rows();
      k = active_cols();
      for (int j = 0; j < k; j++) begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += longint'(basis[i][j]) * longint'(vec[i]);
        proj[j] = floor_clip(acc);
      end
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < k; j++) acc += longint'(basis[i][j]) * longint'(proj[j]);
        y = floor_clip(acc);
        vec[i] = floor_clip(longint'(gain_reg) * longint'(y));
      end
      step_count++;
      for (int i = 0; i < n; i++) begin
        elem.out_value = vec[i];
        elem.out_row = ROW_W'(i);
        elem.step_number = step_count;
        elem.last_of_run = (i == n - 1);
        awaited_elements.push_back(elem);
      end
    endfunction

    function void note_request(in_item_t req);
      case (req.action)
        ACT_LOAD_BASIS: basis[req.row_index][req.col_index] = req.load_value;
        ACT_LOAD_VEC:   vec[req.row_index] = req.load_value;
        ACT_ITERATE:    predict_iteration();
        default: ;
      endcase
    endfunction

    function void log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_element(out_item_t got);
      out_item_t want;
      if (awaited_elements.size() == 0) begin
        log_mismatch($sformatf("element with none awaited: row %0d step %0d value %h",
                               got.out_row, got.step_number, got.out_value));
        return;
      end
      want = awaited_elements.pop_front();
      if (got.out_value !== want.out_value)
        log_mismatch($sformatf("step %0d row %0d value: expected %h, got %h",
                               want.step_number, want.out_row, want.out_value, got.out_value));
      if (got.out_row !== want.out_row)
        log_mismatch($sformatf("step %0d row index: expected %0d, got %0d",
                               want.step_number, want.out_row, got.out_row));
      if (got.step_number !== want.step_number)
        log_mismatch($sformatf("row %0d step number: expected %0d, got %0d",
                               want.out_row, want.step_number, got.step_number));
      if (got.last_of_run !== want.last_of_run)
        log_mismatch($sformatf("step %0d row %0d last flag: expected %b, got %b",
                               want.step_number, want.out_row, want.last_of_run,
                               got.last_of_run));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;

  projection_shadow sb = new();

  // Which basis and vector entries hold a defined value. An iterate request
  // is only sent once every entry it reads has been loaded.
  bit basis_set [MAX_ROWS][MAX_COLS];
  bit vec_set [MAX_ROWS];

  // Idle and stall percentages of the current phase, and the remaining
  // length of a forced output hold-off, counted down by the output process.
  int idle_in_pct;
  int stall_out_pct;
  int out_hold_left;

  // Requests accepted so far, fill-in loads and unused actions included.
  int sent_count;

  low_rank_projection_iteration_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run-away guard: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Output side. Handshakes are sampled right after the edge, before any
  // nonblocking update of that edge lands, so the pre-edge values are seen.
  // Ready is then redrawn for the next cycle, or held low during a hold-off.
  initial begin : result_sink
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_element(out_data_o);
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= stall_out_pct);
      end
    end
  end

  function automatic in_item_t make_request(action_e act, int row, int col,
                                            logic [DATA_W-1:0] value);
    in_item_t r;
    r.action = act;
    r.row_index = ROW_W'(row);
    r.col_index = COL_W'(col);
    r.load_value = value;
    return r;
  endfunction

  // Mostly small Q16.16 values in -3.0..3.0 so the iterations stay in range,
  // with the extremes, zero and raw random words mixed in.
  function automatic logic [DATA_W-1:0] random_word();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return 32'h8000_0000;
    if (sel == 1) return 32'h7FFF_FFFF;
    if (sel == 2) return 32'h0000_0000;
    if (sel == 3) return $urandom();
    return 32'($urandom_range(32'h0006_0000, 0)) - 32'h0003_0000;
  endfunction

  // An index inside the size in use most of the time, anywhere in storage otherwise.
  function automatic int pick_index(int in_use, int span);
    if ($urandom_range(99, 0) < 80) return $urandom_range(in_use - 1, 0);
    return $urandom_range(span - 1, 0);
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid is
  // left high on return; it is lowered only by an idle gap or by the pause
  // between phases, so it is never dropped and raised within one step.
  task automatic issue(input in_item_t req);
    if ($urandom_range(99, 0) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < idle_in_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(req);
    sent_count++;
    case (req.action)
      ACT_LOAD_BASIS: basis_set[req.row_index][req.col_index] = 1'b1;
      ACT_LOAD_VEC:   vec_set[req.row_index] = 1'b1;
      ACT_ITERATE:    for (int i = 0; i < sb.active_rows(); i++) vec_set[i] = 1'b1;
      default: ;
    endcase
  endtask

  // Loads whatever the next iteration would read undefined, then iterates.
  // Fields that an iterate request ignores carry random bits.
  task automatic iterate_once();
    int n;
    int k;
    n = sb.active_rows();
    k = sb.active_cols();
    for (int i = 0; i < n; i++) begin
      if (!vec_set[i])
        issue(make_request(ACT_LOAD_VEC, i, $urandom_range(15, 0), random_word()));
      for (int j = 0; j < k; j++)
        if (!basis_set[i][j]) issue(make_request(ACT_LOAD_BASIS, i, j, random_word()));
    end
    issue(make_request(ACT_ITERATE, $urandom_range(63, 0), $urandom_range(15, 0), $urandom()));
  endtask

  // Configuration changes only while the block is idle: the sender stops,
  // every awaited element is collected, and trailing loads get time to land.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.awaited_elements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers. The size registers get random bits above
  // their width, which the block has to drop. Write enable stays high across
  // the three writes and drops once at the end.
  task automatic program_registers(input logic [CFG_ROWS_W-1:0] rows,
                                   input logic [CFG_COLS_W-1:0] cols,
                                   input logic [DATA_W-1:0] g);
    logic [DATA_W-1:0] rows_word;
    logic [DATA_W-1:0] cols_word;
    rows_word = $urandom();
    cols_word = $urandom();
    rows_word[CFG_ROWS_W-1:0] = rows;
    cols_word[CFG_COLS_W-1:0] = cols;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROWS;
    cfg_data_i  <= rows_word;
    @(posedge clk_i);
    sb.set_register(CFG_ROWS, rows_word);
    cfg_index_i <= CFG_COLS;
    cfg_data_i  <= cols_word;
    @(posedge clk_i);
    sb.set_register(CFG_COLS, cols_word);
    cfg_index_i <= CFG_GAIN;
    cfg_data_i  <= g;
    @(posedge clk_i);
    sb.set_register(CFG_GAIN, g);
    cfg_we_i <= 1'b0;
  endtask

  // One random phase: new settings, then load sequences that end in an
  // iterate request, with some unused-action noise. The phase ends once it
  // has sent the given number of requests, fill-in loads included.
  task automatic run_phase(input logic [CFG_ROWS_W-1:0] rows, input logic [CFG_COLS_W-1:0] cols,
                           input logic [DATA_W-1:0] g, input int items,
                           input int in_pct, input int out_pct);
    int first;
    int pick;
    settle();
    program_registers(rows, cols, g);
    idle_in_pct = in_pct;
    stall_out_pct = out_pct;
    first = sent_count;
    while (sent_count - first < items) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        issue(make_request(ACT_UNUSED, $urandom_range(63, 0), $urandom_range(15, 0),
                           $urandom()));
      end else begin
        if (pick < 45)
          issue(make_request(ACT_LOAD_BASIS, pick_index(sb.active_rows(), MAX_ROWS),
                             pick_index(sb.active_cols(), MAX_COLS), random_word()));
        else if (pick < 72)
          issue(make_request(ACT_LOAD_VEC, pick_index(sb.active_rows(), MAX_ROWS),
                             $urandom_range(15, 0), random_word()));
        else
          iterate_once();
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_ROWS;
    cfg_data_i    <= '0;
    idle_in_pct   = 0;
    stall_out_pct = 0;
    out_hold_left = 0;
    sent_count    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on a two-row, one-column basis with the largest gain.
    // All-minimum entries make both 2^62 products add up to 2^63, which wraps
    // the accumulator negative; the back projection and gain then saturate.
    program_registers(7'd2, 5'd1, 32'h7FFF_FFFF);
    issue(make_request(ACT_LOAD_BASIS, 0, 0, 32'h8000_0000));
    issue(make_request(ACT_LOAD_BASIS, 1, 0, 32'h8000_0000));
    issue(make_request(ACT_LOAD_VEC, 0, 0, 32'h8000_0000));
    issue(make_request(ACT_LOAD_VEC, 1, 15, 32'h8000_0000));
    iterate_once();
    // The unused action code produces nothing and changes nothing.
    issue(make_request(ACT_UNUSED, 63, 15, 32'hFFFF_FFFF));
    // Loads at the top row and column lie outside the sizes in use but are kept.
    issue(make_request(ACT_LOAD_BASIS, 63, 15, 32'h7FFF_FFFF));
    issue(make_request(ACT_LOAD_VEC, 63, 0, 32'h7FFF_FFFF));
    issue(make_request(ACT_LOAD_BASIS, 0, 0, 32'h7FFF_FFFF));
    issue(make_request(ACT_LOAD_BASIS, 1, 0, 32'h0001_0000));
    issue(make_request(ACT_LOAD_VEC, 0, 0, 32'h0000_0000));
    issue(make_request(ACT_LOAD_VEC, 1, 0, 32'hFFFF_0000));
    iterate_once();
    iterate_once();

    // Random phases. The settings walk through the size extremes, including
    // zero and oversized values that the block clamps, and several gains.
    // Idling cycles through none, sender only, receiver only, and both.
    // The first full-height phase is mostly the fill-in loads of its first iteration.
    run_phase(7'd1, 5'd1, 32'h0001_0000, 15, 45, 0);
    run_phase(7'd0, 5'd0, 32'h8000_0000, 15, 0, 45);
    run_phase(7'd64, 5'd1, 32'($urandom_range(32'h0001_4000, 32'h0000_C000)), 20, 31, 31);
    run_phase(7'd2, 5'd16, 32'h0000_0000, 15, 0, 0);
    run_phase(7'd127, 5'd1, 32'hFFFF_0000, 15, 45, 0);
    run_phase(7'd2, 5'd31, $urandom(), 15, 0, 45);

    // Back pressure: the output is held off for a long stretch while the
    // sender keeps offering iterate requests, so the output register fills,
    // the sequencer stalls in its emit step and the input stops accepting.
    settle();
    program_registers(7'd8, 5'd4, 32'h0000_8000);
    idle_in_pct = 0;
    stall_out_pct = 0;
    out_hold_left = 500;
    repeat (5) begin
      issue(make_request(ACT_LOAD_VEC, $urandom_range(7, 0), $urandom_range(15, 0),
                         random_word()));
      iterate_once();
    end
    run_phase(7'd8, 5'd4, 32'hFFFF_8000, 15, 31, 31);

    run_phase(7'($urandom_range(12, 1)), 5'($urandom_range(6, 1)),
              32'($urandom_range(32'h0002_0000, 0)) - 32'h0001_0000, 20, 0, 0);
    run_phase(7'd2, 5'd2, 32'h7FFF_FFFF, 15, 31, 31);

    // Drain, then give the block time to show any element nobody asked for.
    stall_out_pct = 0;
    settle();
    repeat (64) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.awaited_elements.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/lrpi_pkg.sv
design/low_rank_projection_iteration_top.sv
tb/sv/low_rank_projection_iteration_top_tb.sv
